// ===== rtl/desfr_pkg.sv =====
// Package for the DES Feistel round: E expansion, P permutation and S-box tables,
// plus the round function built from them. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package desfr_pkg;

   localparam int HalfWidth = 32;
   localparam int KeyWidth  = 48;
   localparam int NumSboxes = 8;

   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [KeyWidth-1:0]  subkey_type;

   // Table entries use DES numbering: position 1 is the most significant bit.
   localparam logic [5:0] E_TABLE [KeyWidth] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TABLE [HalfWidth] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   localparam logic [3:0] SBOX_TABLE [NumSboxes][4][16] = '{
      '{ '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
           4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
         '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
           4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
         '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
           4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
         '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
           4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13} },
      '{ '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
           4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
         '{4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
           4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5},
         '{4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
           4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15},
         '{4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
           4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9} },
      '{ '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
           4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
         '{4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
           4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
         '{4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
           4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7},
         '{4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
           4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12} },
      '{ '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
           4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
         '{4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
           4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9},
         '{4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
           4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4},
         '{4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
           4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14} },
      '{ '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
           4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
         '{4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
           4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6},
         '{4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
           4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14},
         '{4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
           4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3} },
      '{ '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
           4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
         '{4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
           4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8},
         '{4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
           4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6},
         '{4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
           4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13} },
      '{ '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
           4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
         '{4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
           4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6},
         '{4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
           4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2},
         '{4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
           4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12} },
      '{ '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
           4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
         '{4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
           4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2},
         '{4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
           4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8},
         '{4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
           4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11} }
   };

   // Expand the right half to 48 bits through the E table.
   function automatic subkey_type e_expand(input half_type r);
      subkey_type x;
      logic [4:0] pos;
      for (int i = 0; i < KeyWidth; i++) begin
         pos = 5'(HalfWidth - int'(E_TABLE[i]));
         x[KeyWidth-1-i] = r[pos];
      end
      return x;
   endfunction

   // Apply the P permutation to the S-box output.
   function automatic half_type p_permute(input half_type s);
      half_type p;
      logic [4:0] pos;
      for (int i = 0; i < HalfWidth; i++) begin
         pos = 5'(HalfWidth - int'(P_TABLE[i]));
         p[HalfWidth-1-i] = s[pos];
      end
      return p;
   endfunction

   // Round function f(R, K): expansion, key mix, S-boxes, permutation.
   function automatic half_type round_f(input half_type r, input subkey_type k);
      subkey_type x;
      half_type   s;
      logic [5:0] g;
      for (int i = 0; i < NumSboxes; i++) begin
         s[HalfWidth-1-4*i -: 4] = 4'd0;
      end
      x = e_expand(r) ^ k;
      for (int i = 0; i < NumSboxes; i++) begin
         g = x[KeyWidth-1-6*i -: 6];
         // Outer bits pick the row, middle four bits the column.
         s[HalfWidth-1-4*i -: 4] = SBOX_TABLE[i][{g[5], g[0]}][g[4:1]];
      end
      return p_permute(s);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/des_feistel_round.sv =====
// One DES Feistel round with registered input and result stages.
// Depends on desfr_pkg for the E, P and S-box tables and the round function.
//
// Usage:
//   A request is taken at each rising edge where start is high and busy is
//   low. busy is always low: the datapath is a two-register pipeline, so a
//   new request may be issued on every cycle.
//   req_block_in carries the 64-bit block (left half in bits 63..32) and
//   req_round_key the 48-bit subkey for this round.
//   Each request yields exactly one result: rsp_block_out is valid for the
//   single cycle in which rsp_strobe is high. Its left half is the old right
//   half; its right half is old left XOR f(old right, key).
//   Path: the request is captured in the input register, then the round
//   function result is loaded into the result register, which drives
//   rsp_block_out and rsp_strobe.
//   Throughput: one request per cycle, set by the single combinational pass
//   of E, eight S-box lookups and P between the two registers.
//   Reset clears both valid flags; requests in flight are dropped.
//   The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module des_feistel_round
   import desfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_block_in,
   input  wire logic [47:0] req_round_key,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_block_out
);

   logic        req_valid_ff;
   logic [63:0] req_block_ff;
   logic [47:0] req_key_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_block_ff;
   logic [63:0] rsp_block_in;
   half_type    left_half;
   half_type    right_half;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_block_ff <= req_block_in;
      req_key_ff   <= req_round_key;
      rsp_block_ff <= rsp_block_in;
   end

   assign left_half  = req_block_ff[63:32];
   assign right_half = req_block_ff[31:0];

   always_comb begin
      rsp_block_in = {right_half, left_half ^ round_f(right_half, req_key_ff)};
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

   // Every result traces back to a matching earlier request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("result without a matching request");

   // Every request produces its result.
   assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_strobe)
      else $error("request produced no result");

   // The new left half is the old right half of that request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_block_out[63:32] == $past(req_block_in[31:0], 2))
      else $error("half exchange mismatch");

   // The block never refuses a request.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

`default_nettype wire
